// ===== src/utf8_char_limited_truncation_assert.svh =====
// Assertion macros shared by the truncation block's RTL files.
// Standalone header; no other file needed. Bodies are empty when SYNTH is defined.
`ifndef UTF8_CHAR_LIMITED_TRUNCATION_ASSERT_SVH
`define UTF8_CHAR_LIMITED_TRUNCATION_ASSERT_SVH

`ifndef SYNTH

// expression holds at every edge out of reset
`define UTC_ASSERT(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (expr)) \
        else $error("utc assertion failed");

// antecedent implies consequent in the same cycle
`define UTC_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("utc assertion failed");

// antecedent implies consequent in the next cycle
`define UTC_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("utc assertion failed");

`else

`define UTC_ASSERT(lbl, clk, rstn, expr)
`define UTC_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define UTC_ASSERT_NXT(lbl, clk, rstn, ante, cons)

`endif

`endif

// ===== src/utc_pkg.sv =====
// Shared types and constants for the UTF-8 aware truncation block.
// No dependencies; imported by utc_core, utc_outq and the top level.
package utc_pkg;

    localparam int BYTE_W   = 8;
    localparam int REASON_W = 3;
    localparam int CFG_IDX_W = 8;
    localparam int ITEMS_MAX = 4;          // most result items one source byte can cause
    localparam int ITEM_CNT_W = 3;         // holds 0..ITEMS_MAX
    localparam int Q_DEPTH   = 8;
    localparam int Q_PTR_W   = 3;
    localparam int Q_CNT_W   = 4;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_CHAR_LIMIT = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BYTE_LIMIT = 8'd1;

    // stop reasons
    localparam logic [REASON_W-1:0] RSN_SRC_END   = 3'd0;
    localparam logic [REASON_W-1:0] RSN_BYTE_LIM  = 3'd1;
    localparam logic [REASON_W-1:0] RSN_CHAR_LIM  = 3'd2;
    localparam logic [REASON_W-1:0] RSN_BAD_UTF8  = 3'd3;
    localparam logic [REASON_W-1:0] RSN_DANGLING  = 3'd4;

    localparam logic [BYTE_W-1:0] BACKSLASH = 8'h5C;

    typedef struct packed {
        logic [BYTE_W-1:0]   out_byte;
        logic                byte_valid;
        logic                end_of_result;
        logic [REASON_W-1:0] stop_reason;
    } t_item;

    // everything one accepted source byte produces
    typedef struct packed {
        logic [ITEM_CNT_W-1:0]    n;
        t_item [ITEMS_MAX-1:0]    item;
    } t_step;

endpackage

// ===== src/utf8_char_limited_truncation.sv =====
// UTF-8 aware string truncation, top level.
// Depends on utc_pkg, utc_core and utc_outq.
//
// Usage:
//  - Source bytes arrive on i_valid/o_ready with i_in_byte and i_in_last. A zero
//    byte or i_in_last ends the string. Each accepted byte is handled in the
//    cycle it is accepted and causes zero to four result items.
//  - Result items leave on o_valid/i_ready, one per transaction, from an
//    eight-entry queue. The first item of a byte is visible the cycle after
//    the byte's transaction when no older item is still queued.
//  - Throughput: one source byte per cycle while each byte yields at most one
//    item. A byte that completes a k-byte character, or an escape pair, yields
//    k (or 2) items; o_ready drops while more than four items are queued, so
//    a stalled receiver backs up into the source after that.
//  - Configuration: i_cfg_valid/o_cfg_ready with i_cfg_index and i_cfg_data;
//    index 0 is the character limit, 1 the byte limit, others are ignored.
//    o_cfg_ready is always high; write only while the block is idle.
//  - Reset (i_rst_n low, synchronous): both limits go to 255, the queue
//    empties and the string state clears.
module utf8_char_limited_truncation
    import utc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [BYTE_W-1:0]    i_in_byte,
    input  logic                 i_in_last,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [BYTE_W-1:0]    o_out_byte,
    output logic                 o_byte_valid,
    output logic                 o_end_of_result,
    output logic [REASON_W-1:0]  o_stop_reason,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [BYTE_W-1:0]    i_cfg_data
);

    t_step step;
    t_item item;
    logic  space;
    logic  accept;

    assign o_ready     = space;
    assign o_cfg_ready = 1'b1;
    assign accept      = i_valid && space;

    utc_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (accept),
        .i_in_byte   (i_in_byte),
        .i_in_last   (i_in_last),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_step      (step)
    );

    utc_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_step  (step),
        .o_space (space),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_item  (item)
    );

    assign o_out_byte      = item.out_byte;
    assign o_byte_valid    = item.byte_valid;
    assign o_end_of_result = item.end_of_result;
    assign o_stop_reason   = item.stop_reason;

endmodule

// ===== src/utc_core.sv =====
// Per-byte truncation logic: counters, escape and UTF-8 hold state, limit registers.
// Depends on utc_pkg; produces up to four result items per accepted byte.
`include "utf8_char_limited_truncation_assert.svh"

module utc_core
    import utc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_step,
    input  logic [BYTE_W-1:0]    i_in_byte,
    input  logic                 i_in_last,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [BYTE_W-1:0]    i_cfg_data,
    output t_step                o_step
);

    logic [BYTE_W-1:0] r_char_lim;
    logic [BYTE_W-1:0] r_byte_lim;

    logic [BYTE_W-1:0] r_pend [ITEMS_MAX];
    logic [2:0]        r_pend_cnt, n_pend_cnt;
    logic [2:0]        r_exp_len,  n_exp_len;
    logic              r_esc,      n_esc;
    logic [BYTE_W-1:0] r_chars,    n_chars;
    logic [BYTE_W-1:0] r_bytes,    n_bytes;
    logic              r_stopped,  n_stopped;

    logic              pend_we;
    logic [1:0]        pend_addr;

    function automatic logic [2:0] lead_len(input logic [BYTE_W-1:0] b);
        logic [2:0] len;
        if (b[7] == 1'b0)            len = 3'd1;
        else if (b[7:5] == 3'b110)   len = 3'd2;
        else if (b[7:4] == 4'b1110)  len = 3'd3;
        else if (b[7:3] == 5'b11110) len = 3'd4;
        else                         len = 3'd0;
        return len;
    endfunction

    always_comb begin
        logic                ends;
        logic                stop;
        logic [REASON_W-1:0] reason;
        logic [2:0]          len;
        logic [BYTE_W:0]     need;
        t_step               st;

        ends   = (i_in_byte == '0) || i_in_last;
        stop   = 1'b0;
        reason = RSN_SRC_END;
        len    = lead_len(i_in_byte);
        need   = '0;
        st     = '0;

        n_pend_cnt = r_pend_cnt;
        n_exp_len  = r_exp_len;
        n_esc      = r_esc;
        n_chars    = r_chars;
        n_bytes    = r_bytes;
        n_stopped  = r_stopped;
        pend_we    = 1'b0;
        pend_addr  = r_pend_cnt[1:0];

        if (!r_stopped) begin
            if (r_esc) begin
                need = {1'b0, r_bytes} + 9'd2;
                if (i_in_byte == '0) begin
                    stop = 1'b1; reason = RSN_DANGLING;
                end else if (need > {1'b0, r_byte_lim}) begin
                    stop = 1'b1; reason = RSN_BYTE_LIM;
                end else begin
                    st.item[0].out_byte   = BACKSLASH;
                    st.item[0].byte_valid = 1'b1;
                    st.item[1].out_byte   = i_in_byte;
                    st.item[1].byte_valid = 1'b1;
                    st.n      = 3'd2;
                    n_bytes   = need[BYTE_W-1:0];
                    n_chars   = r_chars + 8'd1;
                    n_esc     = 1'b0;
                    if (i_in_last) begin
                        stop = 1'b1; reason = RSN_SRC_END;
                    end
                end
            end else if (r_exp_len != '0) begin
                need = {1'b0, r_bytes} + {6'd0, r_exp_len};
                if (i_in_byte[7:6] != 2'b10) begin
                    // also covers a zero byte
                    stop = 1'b1; reason = RSN_BAD_UTF8;
                end else begin
                    pend_we    = 1'b1;
                    n_pend_cnt = r_pend_cnt + 3'd1;
                    if (n_pend_cnt >= r_exp_len) begin
                        if (need > {1'b0, r_byte_lim}) begin
                            stop = 1'b1; reason = RSN_BYTE_LIM;
                        end else begin
                            // newest byte is the last one of the sequence
                            st.item[0].out_byte = r_pend[0];
                            st.item[1].out_byte = (r_exp_len == 3'd2) ? i_in_byte : r_pend[1];
                            st.item[2].out_byte = (r_exp_len == 3'd3) ? i_in_byte : r_pend[2];
                            st.item[3].out_byte = i_in_byte;
                            for (int k = 0; k < ITEMS_MAX; k++) begin
                                st.item[k].byte_valid = 1'b1;
                            end
                            st.n       = r_exp_len;
                            n_bytes    = need[BYTE_W-1:0];
                            n_chars    = r_chars + 8'd1;
                            n_pend_cnt = '0;
                            n_exp_len  = '0;
                            if (i_in_last) begin
                                stop = 1'b1; reason = RSN_SRC_END;
                            end
                        end
                    end else if (i_in_last) begin
                        stop = 1'b1; reason = RSN_BAD_UTF8;
                    end
                end
            end else begin
                if (i_in_byte == '0) begin
                    stop = 1'b1; reason = RSN_SRC_END;
                end else if (r_bytes >= r_byte_lim) begin
                    stop = 1'b1; reason = RSN_BYTE_LIM;
                end else if (r_chars >= r_char_lim) begin
                    stop = 1'b1; reason = RSN_CHAR_LIM;
                end else if (i_in_byte == BACKSLASH) begin
                    if (i_in_last) begin
                        stop = 1'b1; reason = RSN_DANGLING;
                    end else begin
                        n_esc = 1'b1;
                    end
                end else if (len == 3'd0) begin
                    stop = 1'b1; reason = RSN_BAD_UTF8;
                end else if (len == 3'd1) begin
                    st.item[0].out_byte   = i_in_byte;
                    st.item[0].byte_valid = 1'b1;
                    st.n    = 3'd1;
                    n_bytes = r_bytes + 8'd1;
                    n_chars = r_chars + 8'd1;
                    if (i_in_last) begin
                        stop = 1'b1; reason = RSN_SRC_END;
                    end
                end else begin
                    pend_we    = 1'b1;
                    pend_addr  = 2'd0;
                    n_pend_cnt = 3'd1;
                    n_exp_len  = len;
                    if (i_in_last) begin
                        stop = 1'b1; reason = RSN_BAD_UTF8;
                    end
                end
            end

            if (stop) begin
                if (st.n == '0) begin
                    st.item[0].end_of_result = 1'b1;
                    st.item[0].stop_reason   = reason;
                    st.n = 3'd1;
                end else begin
                    for (int k = 0; k < ITEMS_MAX; k++) begin
                        if (ITEM_CNT_W'(k + 1) == st.n) begin
                            st.item[k].end_of_result = 1'b1;
                            st.item[k].stop_reason   = reason;
                        end
                    end
                end
            end
        end

        // string end or stop: clear the string state; a stop before the end stays stopped
        if (stop || ends) begin
            n_pend_cnt = '0;
            n_exp_len  = '0;
            n_esc      = 1'b0;
            n_chars    = '0;
            n_bytes    = '0;
            n_stopped  = stop && !ends;
        end

        o_step = st;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_char_lim <= 8'd255;
            r_byte_lim <= 8'd255;
            r_pend_cnt <= '0;
            r_exp_len  <= '0;
            r_esc      <= 1'b0;
            r_chars    <= '0;
            r_bytes    <= '0;
            r_stopped  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_CHAR_LIMIT: r_char_lim <= i_cfg_data;
                    REG_BYTE_LIMIT: r_byte_lim <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_step) begin
                r_pend_cnt <= n_pend_cnt;
                r_exp_len  <= n_exp_len;
                r_esc      <= n_esc;
                r_chars    <= n_chars;
                r_bytes    <= n_bytes;
                r_stopped  <= n_stopped;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step && pend_we) begin
            r_pend[pend_addr] <= i_in_byte;
        end
    end

    `UTC_ASSERT_IMP(a_stopped_clean, i_clk, i_rst_n, r_stopped, (r_exp_len == '0) && !r_esc)
    `UTC_ASSERT_IMP(a_esc_no_seq, i_clk, i_rst_n, r_esc, r_exp_len == '0)
    `UTC_ASSERT_IMP(a_seq_count, i_clk, i_rst_n, r_exp_len != '0,
                    (r_pend_cnt != '0) && (r_pend_cnt < r_exp_len))

endmodule

// ===== src/utc_outq.sv =====
// Result queue: takes up to four items per cycle, hands out one per transaction.
// Depends on utc_pkg for the item and step types.
`include "utf8_char_limited_truncation_assert.svh"

module utc_outq
    import utc_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_step i_step,
    output logic  o_space,
    output logic  o_valid,
    input  logic  i_ready,
    output t_item o_item
);

    localparam logic [Q_CNT_W-1:0] SPACE_MAX = Q_CNT_W'(Q_DEPTH - ITEMS_MAX);

    t_item              r_q [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr, r_rd;
    logic [Q_CNT_W-1:0] r_cnt, n_cnt;
    logic [Q_CNT_W-1:0] add;
    logic               pop;

    assign pop     = o_valid && i_ready;
    assign add     = i_push ? Q_CNT_W'(i_step.n) : '0;
    assign n_cnt   = r_cnt + add - Q_CNT_W'(pop);
    assign o_space = (r_cnt <= SPACE_MAX);
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_q[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= r_wr + add[Q_PTR_W-1:0];
            r_rd  <= r_rd + Q_PTR_W'(pop);
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < ITEMS_MAX; k++) begin
            if (i_push && (ITEM_CNT_W'(k) < i_step.n)) begin
                r_q[r_wr + Q_PTR_W'(k)] <= i_step.item[k];
            end
        end
    end

    `UTC_ASSERT(a_cnt_bound, i_clk, i_rst_n, r_cnt <= Q_CNT_W'(Q_DEPTH))
    `UTC_ASSERT_IMP(a_no_overflow, i_clk, i_rst_n, i_push,
                    ({1'b0, r_cnt} + {1'b0, add}) <= (Q_CNT_W + 1)'(Q_DEPTH))
    `UTC_ASSERT_NXT(a_push_shows, i_clk, i_rst_n, i_push && (i_step.n != '0), o_valid)

endmodule
